### hw/rtl/frrc_pkg.sv
`default_nettype none

package frrc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TOP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_EN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_CNT  = 3'd4;

  localparam logic        REQ_LOAD   = 1'b0;
  localparam logic        REQ_RESIZE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_BAD_ALIGN = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_TOO_SMALL = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_OVERLAP   = 3'd6
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  entry_index;
    logic [63:0] name_key;
    logic [31:0] start_address;
    logic [31:0] region_bytes;
    logic [31:0] used_bytes;
    logic [31:0] resize_bytes;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] final_size;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/frrc_stream_if.sv
`default_nettype none

interface frrc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/flash_region_resize_checker_core.sv
`default_nettype none

// Channel   Dir  Payload  Transfer
// in_chan   in   req_t    valid & ready
// out_chan  out  res_t    valid & ready
// cfg_*     in   32b      cfg_we (no back-pressure)
//
// Load: the result goes through S_FIN into the output register. Resize: a search
// pass over the entry table and, when overlap checking is on, a second pass, one
// read per cycle, plus the checks sequenced through a single 33-bit adder.
// Reset (rst_n low, synchronous) clears control and config; table contents
// are undefined until loaded. A finished result waits in the output register.

module flash_region_resize_checker_core
  import frrc_pkg::*;
#(
  parameter int MAX_REGIONS = 16,
  parameter int NAME_BYTES  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  frrc_stream_if.sink                in_chan,
  frrc_stream_if.source              out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW   = $clog2(MAX_REGIONS + 1);
  localparam int NB_W = 8 * NAME_BYTES;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SEARCH = 8'b0000_0010,
    S_ALIGN  = 8'b0000_0100,
    S_ROUND  = 8'b0000_1000,
    S_END    = 8'b0001_0000,
    S_BOUND  = 8'b0010_0000,
    S_OVL    = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  // config
  logic [31:0] flash_top_r;
  logic        align_en_r;
  logic [31:0] alignment_r;
  logic        ovl_en_r;
  logic [4:0]  region_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_top_r  <= 32'hFFFF_FFFF;
      align_en_r   <= 1'b0;
      alignment_r  <= 32'd1;
      ovl_en_r     <= 1'b1;
      region_cnt_r <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FLASH_TOP:  flash_top_r  <= cfg_wdata;
        CFG_ALIGN_EN:   align_en_r   <= cfg_wdata[0];
        CFG_ALIGNMENT:  alignment_r  <= cfg_wdata;
        CFG_OVERLAP_EN: ovl_en_r     <= cfg_wdata[0];
        CFG_REGION_CNT: region_cnt_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] cnt_clip;
  assign cnt_clip = (32'(region_cnt_r) > MAX_REGIONS) ? CW'(MAX_REGIONS) : CW'(region_cnt_r);

  // entry table
  logic [NB_W-1:0] name_mem  [MAX_REGIONS];
  logic [31:0]     start_mem [MAX_REGIONS];
  logic [31:0]     size_mem  [MAX_REGIONS];
  logic [31:0]     used_mem  [MAX_REGIONS];

  logic            ld_we;
  logic [IW-1:0]   ld_addr;
  logic            sz_we;
  logic [IW-1:0]   sz_addr;
  logic [31:0]     sz_wdata;
  logic [IW-1:0]   rd_addr;
  logic [NB_W-1:0] rd_name_r;
  logic [31:0]     rd_start_r;
  logic [31:0]     rd_size_r;
  logic [31:0]     rd_used_r;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      name_mem[ld_addr]  <= in_chan.data.name_key[NB_W-1:0];
      start_mem[ld_addr] <= in_chan.data.start_address;
      used_mem[ld_addr]  <= in_chan.data.used_bytes;
    end
    if (sz_we) begin
      size_mem[sz_addr] <= sz_wdata;
    end
    rd_name_r  <= name_mem[rd_addr];
    rd_start_r <= start_mem[rd_addr];
    rd_size_r  <= size_mem[rd_addr];
    rd_used_r  <= used_mem[rd_addr];
  end

  // sequencer
  state_t          state_r, state_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]   chk_idx_r, chk_idx_nxt;
  logic [IW-1:0]   target_r, target_nxt;
  logic [NB_W-1:0] key_r, key_nxt;
  logic [32:0]     size_r, size_nxt;
  logic [31:0]     mask_r, mask_nxt;
  logic [31:0]     old_r, old_nxt;
  logic [31:0]     start_r, start_nxt;
  logic [31:0]     used_r, used_nxt;
  logic [32:0]     te_r, te_nxt;
  status_t         res_st_r, res_st_nxt;
  logic [31:0]     res_size_r, res_size_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            out_data_r, out_data_nxt;

  // shared adder
  logic [31:0] alu_a, alu_b;
  logic        alu_cin;
  logic [32:0] alu_sum;
  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + 33'(alu_cin);

  logic in_fire;
  logic issue;
  logic [32:0] rnd;
  logic ovl_hit;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;
  assign issue          = (ptr_r < cnt_clip);
  assign rd_addr        = ptr_r[IW-1:0];
  assign rnd            = alu_sum & ~{1'b0, mask_r};
  assign ovl_hit        = chk_vld_r && (chk_idx_r != target_r) &&
                          ({1'b0, start_r} < alu_sum) && (te_r > {1'b0, rd_start_r});

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = ptr_r[IW-1:0];
    target_nxt    = target_r;
    key_nxt       = key_r;
    size_nxt      = size_r;
    mask_nxt      = mask_r;
    old_nxt       = old_r;
    start_nxt     = start_r;
    used_nxt      = used_r;
    te_nxt        = te_r;
    res_st_nxt    = res_st_r;
    res_size_nxt  = res_size_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;
    ld_we         = 1'b0;
    ld_addr       = IW'(in_chan.data.entry_index);
    sz_we         = 1'b0;
    sz_addr       = target_r;
    sz_wdata      = size_r[31:0];
    alu_a         = 32'd0;
    alu_b         = 32'd0;
    alu_cin       = 1'b0;

    case (state_r)
      S_IDLE: begin
        ptr_nxt = '0;
        if (in_fire) begin
          if (in_chan.data.req_type == REQ_LOAD) begin
            if (32'(in_chan.data.entry_index) < MAX_REGIONS) begin
              ld_we        = 1'b1;
              sz_we        = 1'b1;
              sz_addr      = IW'(in_chan.data.entry_index);
              sz_wdata     = in_chan.data.region_bytes;
              res_st_nxt   = ST_OK;
              res_size_nxt = in_chan.data.region_bytes;
            end else begin
              res_st_nxt   = ST_INVALID;
              res_size_nxt = 32'd0;
            end
            state_nxt = S_FIN;
          end else begin
            key_nxt   = in_chan.data.name_key[NB_W-1:0];
            size_nxt  = {1'b0, in_chan.data.resize_bytes};
            state_nxt = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        ptr_nxt     = ptr_r + CW'(issue);
        chk_vld_nxt = issue;
        if (chk_vld_r && (rd_name_r == key_r)) begin
          target_nxt = chk_idx_r;
          old_nxt    = rd_size_r;
          start_nxt  = rd_start_r;
          used_nxt   = rd_used_r;
          if (size_r == 33'd0) begin
            res_st_nxt   = ST_INVALID;
            res_size_nxt = rd_size_r;
            state_nxt    = S_FIN;
          end else if (align_en_r) begin
            state_nxt = S_ALIGN;
          end else begin
            state_nxt = S_END;
          end
        end else if (!chk_vld_r && !issue) begin
          res_st_nxt   = ST_NOT_FOUND;
          res_size_nxt = 32'd0;
          state_nxt    = S_FIN;
        end
      end

      S_ALIGN: begin
        alu_a = alignment_r;
        alu_b = 32'hFFFF_FFFF;
        if ((alignment_r == 32'd0) || ((alignment_r & alu_sum[31:0]) != 32'd0)) begin
          res_st_nxt   = ST_BAD_ALIGN;
          res_size_nxt = old_r;
          state_nxt    = S_FIN;
        end else begin
          mask_nxt  = alu_sum[31:0];
          state_nxt = S_ROUND;
        end
      end

      S_ROUND: begin
        alu_a = size_r[31:0];
        alu_b = mask_r;
        if (rnd[32]) begin
          res_st_nxt   = ST_OVERFLOW;
          res_size_nxt = old_r;
          state_nxt    = S_FIN;
        end else begin
          size_nxt  = rnd;
          state_nxt = S_END;
        end
      end

      S_END: begin
        alu_a     = start_r;
        alu_b     = size_r[31:0];
        te_nxt    = alu_sum;
        state_nxt = S_BOUND;
      end

      S_BOUND: begin
        alu_a   = flash_top_r;
        alu_cin = 1'b1;
        ptr_nxt = '0;
        if (te_r > alu_sum) begin
          res_st_nxt   = ST_OVERFLOW;
          res_size_nxt = old_r;
          state_nxt    = S_FIN;
        end else if (size_r[31:0] < used_r) begin
          res_st_nxt   = ST_TOO_SMALL;
          res_size_nxt = old_r;
          state_nxt    = S_FIN;
        end else if (ovl_en_r) begin
          state_nxt = S_OVL;
        end else begin
          sz_we        = 1'b1;
          res_st_nxt   = ST_OK;
          res_size_nxt = size_r[31:0];
          state_nxt    = S_FIN;
        end
      end

      S_OVL: begin
        alu_a       = rd_start_r;
        alu_b       = rd_size_r;
        ptr_nxt     = ptr_r + CW'(issue);
        chk_vld_nxt = issue;
        if (ovl_hit) begin
          res_st_nxt   = ST_OVERLAP;
          res_size_nxt = old_r;
          state_nxt    = S_FIN;
        end else if (!chk_vld_r && !issue) begin
          sz_we        = 1'b1;
          res_st_nxt   = ST_OK;
          res_size_nxt = size_r[31:0];
          state_nxt    = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = res_st_r;
          out_data_nxt.final_size = res_size_r;
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    target_r   <= target_nxt;
    key_r      <= key_nxt;
    size_r     <= size_nxt;
    mask_r     <= mask_nxt;
    old_r      <= old_nxt;
    start_r    <= start_nxt;
    used_r     <= used_nxt;
    te_r       <= te_nxt;
    res_st_r   <= res_st_nxt;
    res_size_r <= res_size_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
